// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file rhsd_checker.sv.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, switched off while in reset.
`define RHSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication over the next clock, switched off while in reset.
`define RHSD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- src/rhsd_pkg.sv -----
// Shared constants, types and channel arithmetic for the RGBA 2x2 downscaler.
// No dependencies.
package rhsd_pkg;

    localparam int DEFAULT_MAX_WIDTH = 4096;

    localparam int PIXEL_W  = 32;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int SUM_W    = CHAN_W + 1;
    localparam int PAIR_W   = SUM_W * NUM_CHAN;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_W       = 12;
    localparam int FRAME_W     = 8;
    localparam int FRAMES_W    = 9;
    localparam int MIN_DIM     = 2;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_FRAMES  = 1;
    localparam int MAX_FRAMES  = 256;

    localparam logic [CFG_W-1:0]    RESET_WIDTH  = CFG_W'(2);
    localparam logic [CFG_W-1:0]    RESET_HEIGHT = CFG_W'(2);
    localparam logic [FRAMES_W-1:0] RESET_FRAMES = FRAMES_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_FRAME_COUNT   = 2'd2
    } cfg_reg_t;

    typedef logic [PAIR_W-1:0]  pair_sum_t;
    typedef logic [PIXEL_W-1:0] pixel_t;

    // Per-channel sums of two pixels, channel c at bit SUM_W*c.
    function automatic pair_sum_t pair_sum(input pixel_t a, input pixel_t b);
        pair_sum_t packed_sum;
        packed_sum = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            packed_sum[c*SUM_W +: SUM_W] = {1'b0, a[c*CHAN_W +: CHAN_W]}
                                         + {1'b0, b[c*CHAN_W +: CHAN_W]};
        end
        return packed_sum;
    endfunction

    // Rounded mean of four pixels from two pair sums: (s + 2) >> 2 per channel.
    function automatic pixel_t average_sums(input pair_sum_t upper, input pair_sum_t lower);
        pixel_t          result;
        logic [SUM_W+1:0] s;
        result = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            s = {1'b0, upper[c*SUM_W +: SUM_W]} + {1'b0, lower[c*SUM_W +: SUM_W]}
              + (SUM_W+2)'(2);
            result[c*CHAN_W +: CHAN_W] = s[CHAN_W+1:2];
        end
        return result;
    endfunction

endpackage

// ----- src/rhsd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module rhsd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/rgba_half_size_downscaler.sv -----
// m_tvalid rises in the cycle after the right pixel of a 2x2 block (odd row) is taken.
// Takes one pixel per clock while s_tready is high; gives one per four in used area.
// The line store is read on the left pixel of each odd-row pair and written on the
// right pixel of each even-row pair, so the single RAM port pair never contends.
// Reset (rst_n, async, low): counters at frame start, registers at width 2, height 2,
// one frame, output empty; the line store is not cleared and needs no clearing pass.
module rgba_half_size_downscaler #(
    parameter int MAX_WIDTH = rhsd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [rhsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rhsd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rhsd_pkg::PIXEL_W-1:0]   s_tdata,   // [31:0] pixel_in
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rhsd_pkg::PIXEL_W-1:0]   m_tdata,   // [31:0] pixel_out
    output logic                            m_tlast,   // frame_end
    output logic                            m_tuser    // [0] buffer_end
);

    localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W  = COL_W + 1;
    localparam int DEPTH  = MAX_WIDTH / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (WID_W > rhsd_pkg::CFG_W) ? WID_W : rhsd_pkg::CFG_W;
    localparam int CW     = rhsd_pkg::CFG_W;
    localparam int FW     = rhsd_pkg::FRAMES_W;

    // configuration
    logic [CW-1:0] width_cfg_reg, height_cfg_reg;
    logic [FW-1:0] frames_cfg_reg;
    logic          cfg_hit;

    // position
    logic [COL_W-1:0]             col_reg, col_next;
    logic [rhsd_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [rhsd_pkg::FRAME_W-1:0] frame_reg, frame_next;
    rhsd_pkg::pixel_t             left_reg;

    // output stage
    logic             out_valid_reg, out_valid_next;
    rhsd_pkg::pixel_t out_pixel_reg;
    logic             out_fend_reg, out_bend_reg;

    logic [CMP_W-1:0] width_ext;
    logic [WID_W-1:0] width_eff, used_cols, col_ext;
    logic [CW-1:0]    height_eff, used_rows, row_ext;
    logic [FW-1:0]    frames_eff, frame_ext;
    logic             in_acc, in_area, col_last, row_last, frame_last;
    logic             line_wr, line_rd, emit, fend, bend;
    logic [ADDR_W-1:0] slot;
    rhsd_pkg::pair_sum_t pair_now, pair_above;

    assign cfg_hit = cfg_wr_en && (cfg_index == rhsd_pkg::REG_SOURCE_WIDTH
                                || cfg_index == rhsd_pkg::REG_SOURCE_HEIGHT
                                || cfg_index == rhsd_pkg::REG_FRAME_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= rhsd_pkg::RESET_WIDTH;
            height_cfg_reg <= rhsd_pkg::RESET_HEIGHT;
            frames_cfg_reg <= rhsd_pkg::RESET_FRAMES;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rhsd_pkg::REG_SOURCE_WIDTH:  width_cfg_reg  <= cfg_data;
                rhsd_pkg::REG_SOURCE_HEIGHT: height_cfg_reg <= cfg_data;
                rhsd_pkg::REG_FRAME_COUNT:   frames_cfg_reg <= cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // saturate the geometry into its usable range
    assign width_ext = CMP_W'(width_cfg_reg);
    always_comb
    begin
        priority if (width_ext < CMP_W'(rhsd_pkg::MIN_DIM))
            width_eff = WID_W'(rhsd_pkg::MIN_DIM);
        else if (width_ext > CMP_W'(MAX_WIDTH))
            width_eff = WID_W'(MAX_WIDTH);
        else
            width_eff = width_ext[WID_W-1:0];

        priority if (height_cfg_reg < CW'(rhsd_pkg::MIN_DIM))
            height_eff = CW'(rhsd_pkg::MIN_DIM);
        else if (height_cfg_reg > CW'(rhsd_pkg::MAX_HEIGHT))
            height_eff = CW'(rhsd_pkg::MAX_HEIGHT);
        else
            height_eff = height_cfg_reg;

        priority if (frames_cfg_reg < FW'(rhsd_pkg::MIN_FRAMES))
            frames_eff = FW'(rhsd_pkg::MIN_FRAMES);
        else if (frames_cfg_reg > FW'(rhsd_pkg::MAX_FRAMES))
            frames_eff = FW'(rhsd_pkg::MAX_FRAMES);
        else
            frames_eff = frames_cfg_reg;
    end

    assign used_cols = {width_eff[WID_W-1:1], 1'b0};
    assign used_rows = {height_eff[CW-1:1], 1'b0};
    assign col_ext   = WID_W'(col_reg);
    assign row_ext   = CW'(row_reg);
    assign frame_ext = FW'(frame_reg);

    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign in_area  = (col_ext < used_cols) && (row_ext < used_rows);

    // even row, right pixel: store pair; odd row, left pixel: fetch pair above
    assign line_wr = in_acc && in_area && col_reg[0] && !row_reg[0];
    assign line_rd = in_acc && in_area && !col_reg[0] && row_reg[0];
    assign emit    = in_acc && in_area && col_reg[0] && row_reg[0];
    assign slot    = ADDR_W'(col_reg >> 1);

    assign pair_now = rhsd_pkg::pair_sum(left_reg, s_tdata);

    rhsd_ram #(
        .WIDTH  (rhsd_pkg::PAIR_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (slot),
        .wr_data (pair_now),
        .rd_en   (line_rd),
        .rd_addr (slot),
        .rd_data (pair_above)
    );

    assign fend = (row_ext == used_rows - CW'(1)) && (col_ext == used_cols - WID_W'(1));
    assign bend = fend && (frame_ext >= frames_eff - FW'(1));

    assign col_last   = (col_ext + WID_W'(1)) >= width_eff;
    assign row_last   = (row_ext + CW'(1)) >= height_eff;
    assign frame_last = (frame_ext + FW'(1)) >= frames_eff;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        frame_next = frame_reg;
        if (cfg_hit)
        begin
            col_next   = '0;
            row_next   = '0;
            frame_next = '0;
        end
        else if (in_acc)
        begin
            if (col_last)
            begin
                col_next = '0;
                if (row_last)
                begin
                    row_next   = '0;
                    frame_next = frame_last ? '0 : frame_reg + 1'b1;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        priority if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            frame_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
            if (in_acc && in_area && !col_reg[0])
            begin
                left_reg <= s_tdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_pixel_reg <= rhsd_pkg::average_sums(pair_above, pair_now);
            out_fend_reg  <= fend;
            out_bend_reg  <= bend;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_fend_reg;
    assign m_tuser  = out_bend_reg;

endmodule

// ----- src/rhsd_checker.sv -----
// Port-level checks for the RGBA 2x2 downscaler, bound to the top level.
// Depends on rhsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rhsd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rhsd_pkg::PIXEL_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser
);

    // the last beat of the buffer is always the last beat of a frame
    `RHSD_ASSERT(a_buffer_end_is_frame_end, !m_tvalid || !m_tuser || m_tlast, "buffer end without frame end")

    // an empty output stage never holds off the input
    `RHSD_ASSERT(a_ready_when_empty, m_tvalid || s_tready, "input stalled with output empty")

    // a fresh result needs an input beat on the cycle before
    `RHSD_ASSERT(a_result_has_cause, !(m_tvalid && !$past(m_tvalid)) || $past(s_tvalid && s_tready), "result without input beat")

    // a stalled result holds
    `RHSD_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output changed under stall")

endmodule

bind rgba_half_size_downscaler rhsd_checker u_rhsd_checker (.*);

// ----- dv/tb_rgba_half_size_downscaler.sv -----
// Self-checking testbench for rgba_half_size_downscaler: drives raster pixel beats,
// predicts the 2x2 rounded means with frame/buffer end flags and checks every output beat.
// Depends on rhsd_pkg and the rgba_half_size_downscaler RTL.
module tb_rgba_half_size_downscaler;

    timeunit 1ns;
    timeprecision 1ps;

    import rhsd_pkg::*;

    localparam int LINE_SLOTS    = DEFAULT_MAX_WIDTH / 2;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_PRINTED   = 100;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Which registers a reconfiguration touches.
    localparam logic [3:0] SET_WIDTH    = 4'b0001;
    localparam logic [3:0] SET_HEIGHT   = 4'b0010;
    localparam logic [3:0] SET_FRAMES   = 4'b0100;
    localparam logic [3:0] SET_SPARE    = 4'b1000;
    localparam logic [3:0] SET_GEOMETRY = SET_WIDTH | SET_HEIGHT | SET_FRAMES;

    typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_HELD} rx_mode_t;

    typedef struct packed {
        pixel_t px;
        logic   frame_end;
        logic   buffer_end;
    } mean_beat_t;

    function automatic int unsigned bounded(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    class half_size_scoreboard;
        logic [CFG_W-1:0]    width_reg;
        logic [CFG_W-1:0]    height_reg;
        logic [FRAMES_W-1:0] frames_reg;
        pair_sum_t           even_row_sums [LINE_SLOTS];
        pixel_t              left_px;
        logic [ROW_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [FRAME_W-1:0]  frame;
        mean_beat_t          awaited_means [$];
        int unsigned         fail_count;
        int unsigned         beats_seen;

        function new();
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            frames_reg = RESET_FRAMES;
            left_px    = '0;
            fail_count = 0;
            beats_seen = 0;
            foreach (even_row_sums[i])
                even_row_sums[i] = '0;
            restart();
        endfunction

        function void restart();
            col   = '0;
            row   = '0;
            frame = '0;
        endfunction

        function int unsigned pending();
            return awaited_means.size();
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
            case (cfg_reg_t'(idx))
                REG_SOURCE_WIDTH:  width_reg  = value;
                REG_SOURCE_HEIGHT: height_reg = value;
                REG_FRAME_COUNT:   frames_reg = value[FRAMES_W-1:0];
                default:           return;
            endcase
            restart();
        endfunction

        function pair_sum_t channel_pair(input pixel_t a, input pixel_t b);
            pair_sum_t sums;
            sums = '0;
            for (int c = 0; c < NUM_CHAN; c++)
                sums[c*SUM_W +: SUM_W] = SUM_W'(int'(a[c*CHAN_W +: CHAN_W])
                                               + int'(b[c*CHAN_W +: CHAN_W]));
            return sums;
        endfunction

        function pixel_t block_mean(input pair_sum_t upper, input pair_sum_t lower);
            pixel_t      mean;
            int unsigned total;
            mean = '0;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                total = int'(upper[c*SUM_W +: SUM_W]) + int'(lower[c*SUM_W +: SUM_W]) + 2;
                mean[c*CHAN_W +: CHAN_W] = CHAN_W'(total / 4);
            end
            return mean;
        endfunction

        // One accepted source pixel: update position and line sums, maybe expect a beat.
        function void take_source_pixel(input pixel_t px);
            int unsigned w, h, f, used_cols, used_rows, c, r, slot;
            pair_sum_t   lower;
            mean_beat_t  beat;
            w = bounded(width_reg, MIN_DIM, DEFAULT_MAX_WIDTH);
            h = bounded(height_reg, MIN_DIM, MAX_HEIGHT);
            f = bounded(frames_reg, MIN_FRAMES, MAX_FRAMES);
            used_cols = w & ~32'd1;
            used_rows = h & ~32'd1;
            c = col;
            r = row;
            if (c < used_cols && r < used_rows)
            begin
                if (c % 2 == 0)
                    left_px = px;
                else
                begin
                    lower = channel_pair(left_px, px);
                    slot  = (c / 2) % LINE_SLOTS;
                    if (r % 2 == 0)
                        even_row_sums[slot] = lower;
                    else
                    begin
                        beat.px         = block_mean(even_row_sums[slot], lower);
                        beat.frame_end  = (r == used_rows - 1) && (c == used_cols - 1);
                        beat.buffer_end = beat.frame_end && (frame >= f - 1);
                        awaited_means.push_back(beat);
                    end
                end
            end
            if (c + 1 >= w)
            begin
                col = '0;
                if (r + 1 >= h)
                begin
                    row = '0;
                    if (frame + 1 >= f)
                        frame = '0;
                    else
                        frame = FRAME_W'(frame + 1);
                end
                else
                    row = ROW_W'(r + 1);
            end
            else
                col = ROW_W'(c + 1);
        endfunction

        task report(input string what);
            fail_count++;
            if (fail_count <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(input pixel_t px, input logic fend, input logic bend);
            mean_beat_t want;
            beats_seen++;
            if (awaited_means.size() == 0)
            begin
                report($sformatf("beat %0d unexpected, pixel %h", beats_seen, px));
                return;
            end
            want = awaited_means.pop_front();
            if (px !== want.px)
                report($sformatf("beat %0d pixel %h, want %h", beats_seen, px, want.px));
            if (fend !== want.frame_end)
                report($sformatf("beat %0d frame end %b, want %b", beats_seen, fend,
                                 want.frame_end));
            if (bend !== want.buffer_end)
                report($sformatf("beat %0d buffer end %b, want %b", beats_seen, bend,
                                 want.buffer_end));
        endtask

        task report_missing();
            report($sformatf("%0d beats never came", awaited_means.size()));
            awaited_means.delete();
        endtask
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIXEL_W-1:0]   s_tdata   = '0;   // [31:0] pixel_in
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [PIXEL_W-1:0]   m_tdata;          // [31:0] pixel_out
    logic                 m_tlast;          // frame_end
    logic                 m_tuser;          // [0] buffer_end

    half_size_scoreboard board = new();

    int unsigned burst_left = 0;
    rx_mode_t    rx_mode    = RX_OPEN;
    int unsigned rx_left    = 0;

    rgba_half_size_downscaler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Receiver: runs of free flow, random, sparse and fully held ready.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HELD) ? $urandom_range(1, 16) : $urandom_range(1, 40);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tlast, m_tuser);
    end

    function automatic pixel_t random_pixel();
        pixel_t px;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            case ($urandom_range(0, 7))
                0:       px[c*CHAN_W +: CHAN_W] = '0;
                1:       px[c*CHAN_W +: CHAN_W] = '1;
                default: px[c*CHAN_W +: CHAN_W] = CHAN_W'($urandom);
            endcase
        end
        return px;
    endfunction

    // Bursts of back-to-back beats with random gaps; tvalid stays up within a burst.
    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 64);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        board.take_source_pixel(px);
    endtask

    task automatic send_random(input int unsigned count);
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel());
    endtask

    // Hold the source until every expected beat is out, then let the pipe settle.
    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (board.pending() != 0)
            board.report_missing();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_wr_en high; set_geometry drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.write_reg(idx, value);
    endtask

    task automatic set_geometry(input logic [3:0] which, input logic [CFG_W-1:0] width_val,
                                input logic [CFG_W-1:0] height_val,
                                input logic [CFG_W-1:0] frames_val);
        wait_idle();
        if (which & SET_WIDTH)
            write_reg(REG_SOURCE_WIDTH, width_val);
        if (which & SET_HEIGHT)
            write_reg(REG_SOURCE_HEIGHT, height_val);
        if (which & SET_FRAMES)
            write_reg(REG_FRAME_COUNT, frames_val);
        if (which & SET_SPARE)
            write_reg(REG_UNUSED, CFG_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int unsigned source_total, n, drain_at, block_px;
        logic [CFG_W-1:0] w_pick, h_pick, f_pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry is one 2x2 block per frame: saturation and rounding corners.
        repeat (4) send_pixel(32'hFFFF_FFFF);
        repeat (4) send_pixel(32'h0000_0000);
        send_pixel(32'hFF03_0201);
        send_pixel(32'hFF00_0000);
        send_pixel(32'hFF00_0000);
        send_pixel(32'hFE00_0000);

        // Odd width and height: last column and last row give nothing.
        set_geometry(SET_GEOMETRY, 13'd3, 13'd3, 13'd1);
        send_random(9);

        // A write to the spare index must not restart the frame.
        set_geometry(SET_GEOMETRY, 13'd2, 13'd4, 13'd1);
        send_random(4);
        set_geometry(SET_SPARE, '0, '0, '0);
        send_random(4);

        // Widest line (saturated): the start of its first row must give nothing.
        set_geometry(SET_GEOMETRY, 13'h1FFF, 13'h0000, 13'h0000);
        send_random(128);

        // Tallest frame (saturated), narrow below range; only its first rows.
        set_geometry(SET_GEOMETRY, 13'd1, 13'h1FFF, 13'd2);
        send_random(64);

        // Frame count above range: no buffer end within the first frames.
        set_geometry(SET_GEOMETRY, 13'd0, 13'd1, 13'h1FFF);
        send_random(64);

        source_total = 0;
        while (source_total < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       w_pick = CFG_W'($urandom_range(0, 1));
                1:       w_pick = CFG_W'($urandom_range(11, 40));
                default: w_pick = CFG_W'($urandom_range(2, 10));
            endcase
            h_pick = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 1))
                                                 : CFG_W'($urandom_range(2, 9));
            case ($urandom_range(0, 9))
                0:       f_pick = '0;
                1:       f_pick = CFG_W'($urandom_range(5, 9));
                default: f_pick = CFG_W'($urandom_range(1, 4));
            endcase
            set_geometry(4'($urandom_range(0, 15)), w_pick, h_pick, f_pick);

            block_px = bounded(w_pick, MIN_DIM, DEFAULT_MAX_WIDTH)
                     * bounded(h_pick, MIN_DIM, MAX_HEIGHT);
            n = block_px * $urandom_range(1, 2) + $urandom_range(0, block_px);
            if (n > 400)
                n = 400;
            drain_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : 0;
            for (int i = 1; i <= n; i++)
            begin
                send_pixel(random_pixel());
                if (i == drain_at)
                    wait_idle();
            end
            source_total += n;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.fail_count == 0)
            $display("** rgba_half_size_downscaler: PASSED **");
        else
            $display("** rgba_half_size_downscaler: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** rgba_half_size_downscaler: FAILED **");
        $finish;
    end

endmodule
